// File: src/sgbr_pkg.sv
// Shared types, codes, constants and the glyph font for the glyph band renderer.
package sgbr_pkg;

  // Signed width for page coordinates once glyph and block offsets are added
  localparam int CoordW = 18;

  localparam int GlyphCount  = 38;
  localparam int GlyphCols   = 5;
  localparam int GlyphDots   = 8;
  localparam int DigitGlyphs = 10;
  localparam int GlyphDash   = 36;
  localparam int GlyphPlus   = 37;

  localparam int QueueDepth = 4;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharA    = 8'h41;
  localparam logic [7:0] CharZ    = 8'h5a;
  localparam logic [7:0] CharDash = 8'h2d;
  localparam logic [7:0] CharPlus = 8'h2b;

  localparam logic [15:0] BandTopRst    = 16'd0;
  localparam logic [15:0] BandBottomRst = 16'd64;
  localparam logic [10:0] RowWidthRst   = 11'd1024;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_CHAR  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_BAND_TOP    = 2'd0,
    REG_BAND_BOTTOM = 2'd1,
    REG_ROW_WIDTH   = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_GLYPH = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0]         glyph;
    logic [4:0]         scale;
    logic [7:0]         value;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] idx;
  } glyph_sel_t;

  // Column bitmaps, bit k of a column is dot row k
  localparam logic [7:0] FontRom [GlyphCount][GlyphCols] = '{
    '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h22, 8'h41, 8'h49, 8'h49, 8'h36},
    '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3e, 8'h49, 8'h49, 8'h49, 8'h32}, '{8'h01, 8'h01, 8'h61, 8'h19, 8'h07},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h26, 8'h49, 8'h49, 8'h49, 8'h3e},
    '{8'h7c, 8'h12, 8'h11, 8'h12, 8'h7c}, '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7f, 8'h41, 8'h41, 8'h41, 8'h3e},
    '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3e, 8'h41, 8'h41, 8'h51, 8'h32}, '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f},
    '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}, '{8'h61, 8'h41, 8'h41, 8'h7f, 8'h01},
    '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7f, 8'h02, 8'h04, 8'h02, 8'h7f}, '{8'h7f, 8'h06, 8'h08, 8'h30, 8'h7f},
    '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h0f},
    '{8'h3e, 8'h41, 8'h51, 8'h61, 8'h7e}, '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h4f},
    '{8'h22, 8'h45, 8'h49, 8'h51, 8'h22}, '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01},
    '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}, '{8'h07, 8'h18, 8'h60, 8'h18, 8'h07},
    '{8'h3f, 8'h40, 8'h20, 8'h40, 8'h3f}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
    '{8'h00, 8'h08, 8'h08, 8'h08, 8'h00}, '{8'h08, 8'h08, 8'h3e, 8'h08, 8'h08}
  };

  function automatic glyph_sel_t glyph_lookup(input logic [7:0] code);
    glyph_sel_t sel;
    sel.hit = 1'b1;
    sel.idx = '0;
    if (code inside {[CharZero:CharNine]}) begin
      sel.idx = 6'(code - CharZero);
    end else if (code inside {[CharA:CharZ]}) begin
      sel.idx = 6'(code - CharA) + 6'(DigitGlyphs);
    end else if (code == CharDash) begin
      sel.idx = 6'(GlyphDash);
    end else if (code == CharPlus) begin
      sel.idx = 6'(GlyphPlus);
    end else begin
      sel.hit = 1'b0;
    end
    return sel;
  endfunction

  function automatic logic [7:0] font_col(input logic [5:0] g, input logic [2:0] col);
    logic [7:0] bits;
    bits = 8'h00;
    if (int'(g) < GlyphCount && int'(col) < GlyphCols) begin
      bits = FontRom[g][col];
    end
    return bits;
  endfunction

endpackage

// File: src/sgbr_if.sv
// Command and read-response channel interfaces of the glyph band renderer.
interface sgbr_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic [7:0]         char_code;
  logic [4:0]         scale;
  logic [7:0]         pixel_value;

  modport source (
    output valid, opcode, x_pos, y_pos, char_code, scale, pixel_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_pos, y_pos, char_code, scale, pixel_value,
    output ready
  );
endinterface

interface sgbr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;

  modport source (
    output valid, read_value,
    input  ready
  );
  modport sink (
    input  valid, read_value,
    output ready
  );
endinterface

// File: src/sgbr_front.sv
// Command front end: accepts beats, drops commands that draw nothing, classifies the rest.
module sgbr_front import sgbr_pkg::*; (
  sgbr_cmd_if.sink cmd,
  input  logic     accept_en_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     entry_o
);

  glyph_sel_t sel;
  logic       keep;
  logic       ready;

  assign sel   = glyph_lookup(cmd.char_code);
  assign ready = accept_en_i && !full_i;
  assign cmd.ready = ready;

  always_comb begin
    entry_o.x     = cmd.x_pos;
    entry_o.y     = cmd.y_pos;
    entry_o.glyph = sel.idx;
    entry_o.scale = cmd.scale;
    entry_o.value = cmd.pixel_value;
    case (op_e'(cmd.opcode))
      OP_WRITE: begin
        entry_o.kind = KIND_PIXEL;
        keep         = 1'b1;
      end
      OP_FILL: begin
        entry_o.kind = KIND_FILL;
        keep         = cmd.scale != 5'd0;
      end
      OP_CHAR: begin
        entry_o.kind = KIND_GLYPH;
        keep         = (cmd.scale != 5'd0) && sel.hit;
      end
      OP_READ: begin
        entry_o.kind = KIND_READ;
        keep         = 1'b1;
      end
      default: begin
        entry_o.kind = KIND_PIXEL;
        keep         = 1'b0;
      end
    endcase
  end

  assign push_o = cmd.valid && ready && keep;

endmodule

// File: src/sgbr_fifo.sv
// Short command queue between the front end and the drawing back end.
module sgbr_fifo import sgbr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t entry_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t entry_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: src/sgbr_back.sv
// Drawing back end: pixel sequencer, clip and address pipeline, band store, read result.
module sgbr_back import sgbr_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  parameter int unsigned BAND_ROWS     = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  input  cmd_t                                   q_entry_i,
  output logic                                   q_pop_o,
  input  logic [15:0]                            band_top_i,
  input  logic [15:0]                            band_bottom_i,
  input  logic [$clog2(MAX_ROW_WIDTH + 1)-1:0]   stride_i,
  output logic                                   ready_o,
  sgbr_rsp_if.source                             rsp
);

  localparam int unsigned Depth = BAND_ROWS * MAX_ROW_WIDTH;
  localparam int AddrW   = $clog2(Depth);
  localparam int RowW    = $clog2(BAND_ROWS);
  localparam int ColW    = $clog2(MAX_ROW_WIDTH);
  localparam int StrideW = $clog2(MAX_ROW_WIDTH + 1);
  localparam int ProdW   = RowW + StrideW;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_DRAW  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;

  // Loop registers of the glyph or block being drawn
  logic                     fill_q, fill_d;
  logic [5:0]               glyph_q, glyph_d;
  logic [4:0]               scale_q, scale_d;
  logic signed [CoordW-1:0] base_x_q, base_x_d;
  logic signed [CoordW-1:0] org_y_q, org_y_d;
  logic signed [CoordW-1:0] dot_y_q, dot_y_d;
  logic [2:0]               col_q, col_d;
  logic [2:0]               dot_q, dot_d;
  logic [4:0]               i_q, i_d;
  logic [4:0]               j_q, j_d;

  // Pixel stage
  logic                     p1_vld_q;
  logic                     p1_rd_q;
  logic signed [CoordW-1:0] p1_x_q, p1_y_q;
  logic [7:0]               p1_val_q;

  // Clipped stage
  logic            c_vld_q, c_rd_q, c_hit_q;
  logic [RowW-1:0] c_row_q;
  logic [ColW-1:0] c_col_q;
  logic [7:0]      c_val_q;

  // Read data stage and result register
  logic       d_vld_q, d_hit_q;
  logic [7:0] rdata_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;

  logic [7:0] mem [Depth];

  logic                     emit;
  logic                     emit_rd;
  logic signed [CoordW-1:0] emit_x, emit_y;
  logic [7:0]               emit_val;
  logic                     rd_busy;
  logic [7:0]               col_bits;
  logic                     dot_on, last_ij, adv_dot;
  logic signed [CoordW-1:0] head_x, head_y;

  assign ready_o  = state_q != ST_CLEAR;
  assign rd_busy  = (p1_vld_q && p1_rd_q) || (c_vld_q && c_rd_q) || d_vld_q;
  assign col_bits = font_col(glyph_q, col_q);
  assign dot_on   = fill_q || col_bits[dot_q];
  assign last_ij  = (i_q == scale_q - 5'd1) && (j_q == scale_q - 5'd1);
  assign head_x   = {{(CoordW - 16){q_entry_i.x[15]}}, q_entry_i.x};
  assign head_y   = {{(CoordW - 16){q_entry_i.y[15]}}, q_entry_i.y};

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    fill_d   = fill_q;
    glyph_d  = glyph_q;
    scale_d  = scale_q;
    base_x_d = base_x_q;
    org_y_d  = org_y_q;
    dot_y_d  = dot_y_q;
    col_d    = col_q;
    dot_d    = dot_q;
    i_d      = i_q;
    j_d      = j_q;
    q_pop_o  = 1'b0;
    emit     = 1'b0;
    emit_rd  = 1'b0;
    emit_x   = head_x;
    emit_y   = head_y;
    emit_val = q_entry_i.value;
    adv_dot  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.kind)
            KIND_PIXEL: begin
              q_pop_o = 1'b1;
              emit    = 1'b1;
            end
            KIND_READ: begin
              // hold until the single result slot is free
              if (!rd_busy && !out_valid_q) begin
                q_pop_o = 1'b1;
                emit    = 1'b1;
                emit_rd = 1'b1;
              end
            end
            KIND_FILL, KIND_GLYPH: begin
              q_pop_o  = 1'b1;
              fill_d   = q_entry_i.kind == KIND_FILL;
              glyph_d  = q_entry_i.glyph;
              scale_d  = q_entry_i.scale;
              base_x_d = head_x;
              org_y_d  = head_y;
              dot_y_d  = head_y;
              col_d    = '0;
              dot_d    = '0;
              i_d      = '0;
              j_d      = '0;
              state_d  = ST_DRAW;
            end
            default: begin
              q_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_DRAW: begin
        if (dot_on) begin
          emit     = 1'b1;
          emit_x   = base_x_q + $signed({{(CoordW - 5){1'b0}}, i_q});
          emit_y   = dot_y_q + $signed({{(CoordW - 5){1'b0}}, j_q});
          emit_val = 8'd1;
          if (j_q == scale_q - 5'd1) begin
            j_d = '0;
            i_d = i_q + 1'b1;
          end else begin
            j_d = j_q + 1'b1;
          end
          adv_dot = last_ij;
        end else begin
          adv_dot = 1'b1;
        end
        if (adv_dot) begin
          i_d = '0;
          j_d = '0;
          if (fill_q || (col_q == 3'(GlyphCols - 1) && dot_q == 3'(GlyphDots - 1))) begin
            state_d = ST_IDLE;
          end else if (dot_q == 3'(GlyphDots - 1)) begin
            col_d    = col_q + 1'b1;
            dot_d    = '0;
            base_x_d = base_x_q + $signed({{(CoordW - 5){1'b0}}, scale_q});
            dot_y_d  = org_y_q;
          end else begin
            dot_d   = dot_q + 1'b1;
            dot_y_d = dot_y_q + $signed({{(CoordW - 5){1'b0}}, scale_q});
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q   <= fill_d;
    glyph_q  <= glyph_d;
    scale_q  <= scale_d;
    base_x_q <= base_x_d;
    org_y_q  <= org_y_d;
    dot_y_q  <= dot_y_d;
    col_q    <= col_d;
    dot_q    <= dot_d;
    i_q      <= i_d;
    j_q      <= j_d;
  end

  // Clip against the band, the store rows and the row width
  logic signed [CoordW-1:0] dy;
  logic                     hit_d;

  assign dy    = p1_y_q - $signed({{(CoordW - 16){1'b0}}, band_top_i});
  assign hit_d = !dy[CoordW-1]
              && (p1_y_q < $signed({{(CoordW - 16){1'b0}}, band_bottom_i}))
              && (dy < $signed(CoordW'(BAND_ROWS)))
              && !p1_x_q[CoordW-1]
              && (p1_x_q < $signed(CoordW'(stride_i)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q    <= 1'b0;
      c_vld_q     <= 1'b0;
      d_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p1_vld_q <= emit;
      c_vld_q  <= p1_vld_q;
      d_vld_q  <= c_vld_q && c_rd_q;
      if (d_vld_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_rd_q  <= emit_rd;
    p1_x_q   <= emit_x;
    p1_y_q   <= emit_y;
    p1_val_q <= emit_val;
    c_rd_q   <= p1_rd_q;
    c_hit_q  <= hit_d;
    c_row_q  <= dy[RowW-1:0];
    c_col_q  <= p1_x_q[ColW-1:0];
    c_val_q  <= p1_val_q;
    d_hit_q  <= c_hit_q;
    if (d_vld_q) begin
      out_data_q <= d_hit_q ? rdata_q : 8'd0;
    end
  end

  // Store address, one write or read per cycle
  logic [ProdW-1:0] px_sum;
  logic [AddrW-1:0] mem_addr;
  logic             mem_we;
  logic [7:0]       mem_wdata;

  assign px_sum = ProdW'(c_row_q) * ProdW'(stride_i) + ProdW'(c_col_q);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_addr  = clr_q;
      mem_we    = 1'b1;
      mem_wdata = 8'd0;
    end else begin
      mem_addr  = AddrW'(px_sum);
      mem_we    = c_vld_q && c_hit_q && !c_rd_q;
      mem_wdata = c_val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.read_value = out_data_q;

endmodule

// File: src/scaled_glyph_band_renderer.sv
// Band pixel store with pixel, block and 5x8 glyph drawing, behind an APB register port.
// After reset the store, BAND_ROWS * MAX_ROW_WIDTH bytes (65536 by default), is swept
// to zero, one byte per cycle; no command is taken during the sweep, register writes are.
// Commands enter a four-entry queue; fill and draw commands with zero scale, and draw
// commands with an unsupported character, are taken and dropped at the front. The back
// end writes one pixel per cycle through the single store port: a pixel write or read is
// issued at the queue head; a block, s*s pixels, or a glyph, s*s per set dot and a skip
// per unset dot, follows a dispatch from the head. A read result passes the pixel, clipped
// and read data stages to the result register; a read waits until the previous result is taken.
module scaled_glyph_band_renderer import sgbr_pkg::*; #(
  parameter int unsigned MAX_ROW_WIDTH = 1024,
  parameter int unsigned BAND_ROWS     = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sgbr_cmd_if.sink    cmd_i,
  sgbr_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int StrideW = $clog2(MAX_ROW_WIDTH + 1);

  logic [15:0]        band_top_q;
  logic [15:0]        band_bottom_q;
  logic [10:0]        row_width_q;
  logic [StrideW-1:0] stride;

  logic push, full, q_valid, q_pop, back_ready;
  cmd_t push_entry, head_entry;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_top_q    <= BandTopRst;
      band_bottom_q <= BandBottomRst;
      row_width_q   <= RowWidthRst;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[3:2]))
        REG_BAND_TOP:    band_top_q    <= pwdata[15:0];
        REG_BAND_BOTTOM: band_bottom_q <= pwdata[15:0];
        REG_ROW_WIDTH:   row_width_q   <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_BAND_TOP:    prdata = {16'd0, band_top_q};
      REG_BAND_BOTTOM: prdata = {16'd0, band_bottom_q};
      REG_ROW_WIDTH:   prdata = {21'd0, row_width_q};
      default:         prdata = 32'd0;
    endcase
  end

  // Clamp an oversized row width to the store row length
  always_comb begin
    if (32'(row_width_q) > MAX_ROW_WIDTH) begin
      stride = StrideW'(MAX_ROW_WIDTH);
    end else begin
      stride = StrideW'(row_width_q);
    end
  end

  sgbr_front u_front (
    .cmd         (cmd_i),
    .accept_en_i (back_ready),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  sgbr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  sgbr_back #(
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
    .BAND_ROWS     (BAND_ROWS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (head_entry),
    .q_pop_o       (q_pop),
    .band_top_i    (band_top_q),
    .band_bottom_i (band_bottom_q),
    .stride_i      (stride),
    .ready_o       (back_ready),
    .rsp           (rsp_o)
  );

endmodule

// File: test/band_check_pkg.sv
`timescale 1ns / 100ps
// Command record, glyph font and band store mirror used to check the glyph band renderer.
package band_check_pkg;
  import sgbr_pkg::*;

  localparam int MaxRowWidth = 1024;
  localparam int BandRows    = 64;
  localparam int FontGlyphs  = 38;
  localparam int DashGlyph   = 36;
  localparam int PlusGlyph   = 37;
  localparam logic [1:0] SpareRegIdx = 2'd3;

  // Column bitmaps per glyph: digits, letters, dash, plus; bit k is dot row k
  localparam logic [0:FontGlyphs-1][0:4][7:0] GlyphFont = {
    8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e, 8'h00, 8'h42, 8'h7f, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46, 8'h22, 8'h41, 8'h49, 8'h49, 8'h36,
    8'h18, 8'h14, 8'h12, 8'h7f, 8'h10, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3e, 8'h49, 8'h49, 8'h49, 8'h32, 8'h01, 8'h01, 8'h61, 8'h19, 8'h07,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h26, 8'h49, 8'h49, 8'h49, 8'h3e,
    8'h7c, 8'h12, 8'h11, 8'h12, 8'h7c, 8'h7f, 8'h49, 8'h49, 8'h49, 8'h36,
    8'h3e, 8'h41, 8'h41, 8'h41, 8'h22, 8'h7f, 8'h41, 8'h41, 8'h41, 8'h3e,
    8'h7f, 8'h49, 8'h49, 8'h49, 8'h41, 8'h7f, 8'h09, 8'h09, 8'h09, 8'h01,
    8'h3e, 8'h41, 8'h41, 8'h51, 8'h32, 8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f,
    8'h00, 8'h41, 8'h7f, 8'h41, 8'h00, 8'h61, 8'h41, 8'h41, 8'h7f, 8'h01,
    8'h7f, 8'h08, 8'h14, 8'h22, 8'h41, 8'h7f, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h7f, 8'h02, 8'h04, 8'h02, 8'h7f, 8'h7f, 8'h06, 8'h08, 8'h30, 8'h7f,
    8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e, 8'h7f, 8'h09, 8'h09, 8'h09, 8'h0f,
    8'h3e, 8'h41, 8'h51, 8'h61, 8'h7e, 8'h7f, 8'h09, 8'h19, 8'h29, 8'h4f,
    8'h22, 8'h45, 8'h49, 8'h51, 8'h22, 8'h01, 8'h01, 8'h7f, 8'h01, 8'h01,
    8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f, 8'h07, 8'h18, 8'h60, 8'h18, 8'h07,
    8'h3f, 8'h40, 8'h20, 8'h40, 8'h3f, 8'h63, 8'h14, 8'h08, 8'h14, 8'h63,
    8'h03, 8'h04, 8'h78, 8'h04, 8'h03, 8'h61, 8'h51, 8'h49, 8'h45, 8'h43,
    8'h00, 8'h08, 8'h08, 8'h08, 8'h00, 8'h08, 8'h08, 8'h3e, 8'h08, 8'h08
  };

  typedef struct {
    op_e                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         code;
    logic [4:0]         scale;
    logic [7:0]         value;
  } band_cmd_t;

  class band_mirror;
    logic [7:0] pixels [MaxRowWidth*BandRows];
    int         top_row;
    int         bottom_row;
    int         width;
    logic [7:0] pending_reads [$];
    int         mismatches;
    int         reads_checked;
    int         op_count [4];

    function new();
      foreach (pixels[i]) pixels[i] = 8'h00;
      top_row    = 0;
      bottom_row = 64;
      width      = 1024;
      mismatches = 0;
      reads_checked = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      if (idx == REG_BAND_TOP) begin
        top_row = int'(data[15:0]);
      end else if (idx == REG_BAND_BOTTOM) begin
        bottom_row = int'(data[15:0]);
      end else if (idx == REG_ROW_WIDTH) begin
        width = int'(data[10:0]);
      end
    endfunction

    function int stride();
      return (width > MaxRowWidth) ? MaxRowWidth : width;
    endfunction

    function bit locate(int x, int y, output int addr);
      int w;
      int row;
      w    = stride();
      addr = 0;
      if (y < top_row || y >= bottom_row) return 1'b0;
      row = y - top_row;
      if (row >= BandRows) return 1'b0;
      if (x < 0 || x >= w) return 1'b0;
      addr = row * w + x;
      return 1'b1;
    endfunction

    function void plot(int x, int y, logic [7:0] v);
      int addr;
      if (locate(x, y, addr)) pixels[addr] = v;
    endfunction

    function void fill(int x, int y, int s);
      for (int i = 0; i < s; i++) begin
        for (int j = 0; j < s; j++) plot(x + i, y + j, 8'h01);
      end
    endfunction

    function void draw(int x, int y, logic [7:0] code, int s);
      int g;
      if (code >= "0" && code <= "9") begin
        g = int'(code - "0");
      end else if (code >= "A" && code <= "Z") begin
        g = int'(code - "A") + 10;
      end else if (code == "-") begin
        g = DashGlyph;
      end else if (code == "+") begin
        g = PlusGlyph;
      end else begin
        return;
      end
      for (int col = 0; col < 5; col++) begin
        for (int dot = 0; dot < 8; dot++) begin
          if (GlyphFont[g][col][dot]) fill(x + col * s, y + dot * s, s);
        end
      end
    endfunction

    // Apply one accepted command; a read queues the byte it must return
    function void apply(band_cmd_t c);
      int addr;
      op_count[c.op]++;
      case (c.op)
        OP_WRITE: plot(int'(c.x), int'(c.y), c.value);
        OP_FILL:  fill(int'(c.x), int'(c.y), int'(c.scale));
        OP_CHAR:  draw(int'(c.x), int'(c.y), c.code, int'(c.scale));
        default: begin
          if (locate(int'(c.x), int'(c.y), addr)) pending_reads.push_back(pixels[addr]);
          else pending_reads.push_back(8'h00);
        end
      endcase
    endfunction

    function void check_read(logic [7:0] got);
      logic [7:0] want;
      if (pending_reads.size() == 0) begin
        mismatches++;
        $display("%0t unexpected read beat: expected none, actual %02h", $time, got);
        return;
      end
      want = pending_reads.pop_front();
      reads_checked++;
      if (got !== want) begin
        mismatches++;
        $display("%0t read_value mismatch: expected %02h, actual %02h", $time, want, got);
      end
    endfunction
  endclass

endpackage

// File: test/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench: drives commands and register writes into the renderer, checks reads.
module testbench;
  import sgbr_pkg::*;
  import band_check_pkg::*;

  localparam int PhaseCount = 6;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sgbr_cmd_if cmd_bus ();
  sgbr_rsp_if rsp_bus ();

  scaled_glyph_band_renderer #(
    .MAX_ROW_WIDTH(MaxRowWidth),
    .BAND_ROWS    (BandRows)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  band_mirror board = new();
  longint     work_budget = 0;
  int         tail_work = 0;
  int         items_sent = 0;
  bit         steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int work_cycles(band_cmd_t c);
    case (c.op)
      OP_FILL: return int'(c.scale) * int'(c.scale) + 8;
      OP_CHAR: return 40 * int'(c.scale) * int'(c.scale) + 48;
      default: return 8;
    endcase
  endfunction

  function automatic band_cmd_t make_cmd(op_e op, int x, int y, int code, int s, int v);
    band_cmd_t c;
    c.op    = op;
    c.x     = 16'(x);
    c.y     = 16'(y);
    c.code  = 8'(code);
    c.scale = 5'(s);
    c.value = 8'(v);
    return c;
  endfunction

  // Aim most coordinates at the band edges and corners, the rest anywhere on the page
  function automatic band_cmd_t random_cmd();
    band_cmd_t c;
    int r;
    int k;
    int w;
    w = board.stride();
    r = $urandom_range(0, 99);
    c.op = (r < 30) ? OP_WRITE : (r < 45) ? OP_FILL : (r < 65) ? OP_CHAR : OP_READ;
    if (c.op == OP_FILL || c.op == OP_CHAR) begin
      r = $urandom_range(0, 99);
      if (r < 88) c.scale = 5'($urandom_range(0, 3));
      else if (r < 98 || c.op == OP_CHAR) c.scale = 5'($urandom_range(4, 9));
      else c.scale = 5'($urandom_range(10, 31));
    end else begin
      c.scale = 5'($urandom_range(0, 31));
    end
    r = $urandom_range(0, 99);
    if (r < 70) begin
      k = $urandom_range(0, FontGlyphs - 1);
      if (k < 10) c.code = 8'("0" + k);
      else if (k < 36) c.code = 8'("A" + k - 10);
      else if (k == DashGlyph) c.code = "-";
      else c.code = "+";
    end else begin
      c.code = 8'($urandom_range(0, 255));
    end
    c.value = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) c.x = 16'($urandom_range(0, 31) - 4);
    else if (r < 85) c.x = 16'(w - 20 + $urandom_range(0, 28));
    else c.x = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 40) c.y = 16'(board.top_row - 4 + $urandom_range(0, 24));
    else if (r < 60) c.y = 16'(board.top_row + 50 + $urandom_range(0, 20));
    else if (r < 85) c.y = 16'(board.bottom_row - 12 + $urandom_range(0, 16));
    else c.y = 16'($urandom);
    return c;
  endfunction

  task automatic issue_cmd(band_cmd_t c);
    while (!steady && $urandom_range(0, 99) < 25) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.opcode      <= c.op;
    cmd_bus.x_pos       <= c.x;
    cmd_bus.y_pos       <= c.y;
    cmd_bus.char_code   <= c.code;
    cmd_bus.scale       <= c.scale;
    cmd_bus.pixel_value <= c.value;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    board.apply(c);
    items_sent++;
    work_budget += work_cycles(c) + 64;
    // only work queued behind the last read can still be running once its beat is back
    if (c.op == OP_READ) tail_work = 0;
    else tail_work += work_cycles(c);
  endtask

  // Leave psel high so back-to-back writes go straight from access to setup
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    board.set_reg(idx, data);
  endtask

  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (board.pending_reads.size() != 0) @(posedge clk_i);
    repeat (tail_work + 16) @(posedge clk_i);
    tail_work = 0;
  endtask

  // Receiver: random stalls, one calm stretch, one long hold-off to back up the queue
  initial begin
    int hold_left;
    int taken;
    bit hold_done;
    hold_left = 0;
    taken = 0;
    hold_done = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        board.check_read(rsp_bus.read_value);
        taken++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!hold_done && taken == 450) begin
        hold_done = 1'b1;
        hold_left = 3000;
        rsp_bus.ready <= 1'b0;
      end else if (taken >= 200 && taken < 350) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // Watchdog: covers the reset sweep, the hold-off and four times the queued work
  initial begin
    longint cycles;
    cycles = 0;
    while (cycles <= 4 * (work_budget + 120000)) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase_top [PhaseCount]    = '{100, 0, 65535, 32740, 10, 0};
    int phase_bottom [PhaseCount] = '{140, 65535, 0, 32800, 20, 64};
    int phase_width [PhaseCount]  = '{300, 2047, 0, 1025, 8, 1024};
    int phase_items [PhaseCount]  = '{450, 350, 80, 350, 350, 370};
    band_cmd_t directed [$];

    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.opcode      = '0;
    cmd_bus.x_pos       = '0;
    cmd_bus.y_pos       = '0;
    cmd_bus.char_code   = '0;
    cmd_bus.scale       = '0;
    cmd_bus.pixel_value = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass under reset settings: store corners, clip edges, scale and glyph cases
    directed.push_back(make_cmd(OP_WRITE, 0, 0, 0, 0, 255));
    directed.push_back(make_cmd(OP_READ, 0, 0, 255, 31, 0));
    directed.push_back(make_cmd(OP_WRITE, 1023, 63, 0, 31, 8'ha5));
    directed.push_back(make_cmd(OP_READ, 1023, 63, 0, 0, 0));
    directed.push_back(make_cmd(OP_WRITE, 1024, 0, 0, 0, 7));
    directed.push_back(make_cmd(OP_READ, 1024, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_WRITE, -1, 5, 0, 0, 9));
    directed.push_back(make_cmd(OP_WRITE, 5, 64, 0, 0, 9));
    directed.push_back(make_cmd(OP_READ, 5, 64, 0, 0, 0));
    directed.push_back(make_cmd(OP_READ, -32768, -32768, 0, 0, 0));
    directed.push_back(make_cmd(OP_WRITE, 32767, 32767, 255, 31, 8'h5a));
    directed.push_back(make_cmd(OP_READ, 32767, 32767, 0, 0, 0));
    directed.push_back(make_cmd(OP_FILL, 10, 10, 0, 31, 0));
    directed.push_back(make_cmd(OP_READ, 40, 40, 0, 0, 0));
    directed.push_back(make_cmd(OP_READ, 41, 10, 0, 0, 0));
    directed.push_back(make_cmd(OP_FILL, 60, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_READ, 60, 0, 0, 0, 0));
    directed.push_back(make_cmd(OP_CHAR, 100, 0, "+", 31, 0));
    directed.push_back(make_cmd(OP_CHAR, 200, 0, "0", 1, 0));
    directed.push_back(make_cmd(OP_CHAR, 210, 0, "Z", 2, 0));
    directed.push_back(make_cmd(OP_CHAR, 230, 0, "-", 3, 0));
    directed.push_back(make_cmd(OP_CHAR, 240, 56, "9", 2, 0));
    directed.push_back(make_cmd(OP_CHAR, 300, 0, "*", 4, 0));
    directed.push_back(make_cmd(OP_CHAR, 310, 0, 255, 4, 0));
    directed.push_back(make_cmd(OP_READ, 200, 1, 0, 0, 0));
    foreach (directed[i]) issue_cmd(directed[i]);
    settle();

    for (int p = 0; p < PhaseCount; p++) begin
      write_reg(REG_BAND_TOP, {16'($urandom), 16'(phase_top[p])});
      write_reg(REG_BAND_BOTTOM, {16'($urandom), 16'(phase_bottom[p])});
      write_reg(REG_ROW_WIDTH, {21'($urandom), 11'(phase_width[p])});
      // an unmapped index must leave every setting alone
      if (p == 1) write_reg(SpareRegIdx, $urandom);
      psel    <= 1'b0;
      penable <= 1'b0;
      for (int n = 0; n < phase_items[p]; n++) begin
        steady = (items_sent >= 700 && items_sent < 1000);
        issue_cmd(random_cmd());
      end
      settle();
    end

    $display("Sent %0d commands: %0d pixel writes, %0d block fills, %0d glyphs, %0d reads",
             items_sent, board.op_count[OP_WRITE], board.op_count[OP_FILL],
             board.op_count[OP_CHAR], board.op_count[OP_READ]);
    $display("Checked %0d read beats over %0d band and width settings, %0d mismatches",
             board.reads_checked, PhaseCount + 1, board.mismatches);
    if (board.mismatches == 0 && board.pending_reads.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
